// ===== rtl/asq_pkg.sv =====
`timescale 1ns / 1ps

package asq_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SIGNAL = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;
    localparam logic [1:0] REG_MELODY  = 2'd2;
    localparam logic [1:0] REG_VOLUME  = 2'd3;

    localparam int CFG_WIDTH = 40;

    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
    localparam logic [14:0] MODE_RESET    = 15'h7FFF;

    localparam logic [31:0] HOLD_FIRST = 32'd1000;
    localparam logic [31:0] HOLD_OTHER = 32'd10000;
    localparam logic [31:0] HOLD_LAST  = 32'd15000;
    localparam logic [2:0]  SRC_FIRST  = 3'd0;
    localparam logic [2:0]  SRC_LAST   = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  source;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  src_index;
        logic        acknowledged;
        logic [31:0] alert_time_ms;
        logic        sound_start;
        logic [3:0]  melody;
        logic [7:0]  volume;
        logic        vibro_enable;
        logic        led_enable;
        logic        indications_stop;
        logic [2:0]  queue_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic clr_idx;
        logic inc_idx;
        logic drop;
        logic drop_ack;
        logic do_signal;
        logic emit_status;
    } ctl_t;

    typedef struct packed {
        logic       scan_more;
        logic       expired;
        logic       queue_nz;
        logic       out_free;
        logic [1:0] cmd;
    } sts_t;

endpackage

// ===== rtl/asq_if.sv =====
`timescale 1ns / 1ps

interface asq_in_if;
    logic              valid;
    logic              ready;
    asq_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface asq_out_if;
    logic               valid;
    logic               ready;
    asq_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/alert_source_queue.sv =====
`timescale 1ns / 1ps

// Port     Dir  Handshake      Content
// events   in   valid/ready    cmd, source, now_ms
// records  out  valid/ready    log records, then one status record (last)
// cfg      in   cfg_we         cfg_index selects register, cfg_data
//
// A tick passes through the scan and status states, and a signal or cancel also through its own
// state in between; the expiry scan checks one queued entry at a time and a stalled record holds it.
// Each log or status record is loaded into the output register only when that register is free.
// Reset clears queue size, holdoff times and control, and sets the configuration to its defaults, at once.
// A stalled record holds the scan; a new item is taken only once the last
// record is in the output register.

module alert_source_queue
#(
    parameter int SOURCES = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [asq_pkg::CFG_WIDTH-1:0] cfg_data,
    asq_in_if.sink                        events,
    asq_out_if.source                     records
);

    asq_pkg::ctl_t ctl;
    asq_pkg::sts_t sts;

    asq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (events.valid),
        .in_ready (events.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    asq_dp #(.SOURCES(SOURCES)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_payload  (events.payload),
        .ctl         (ctl),
        .sts         (sts),
        .out_valid   (records.valid),
        .out_ready   (records.ready),
        .out_payload (records.payload)
    );

    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && events.ready) |=> !events.ready)
        else $error("second transfer taken while an item is in work");

    ap_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && records.payload.kind) |->
        (records.payload.indications_stop == (records.payload.queue_count == 3'd0)))
        else $error("stop flag disagrees with queue count");

    ap_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid |-> (records.payload.last == records.payload.kind))
        else $error("last flag not on the status record");

    ap_log_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (records.valid && !records.payload.kind) |->
        (!records.payload.sound_start && (records.payload.queue_count == 3'd0)))
        else $error("log record carries status fields");

endmodule

// ===== rtl/asq_ctrl.sv =====
`timescale 1ns / 1ps

module asq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  asq_pkg::sts_t sts,
    output asq_pkg::ctl_t ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_CANCEL = 3'd2;
    localparam logic [2:0] ST_SIGNAL = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    ctl.clr_idx   = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.scan_more)
                begin
                    case (sts.cmd)
                        asq_pkg::CMD_CANCEL:
                        begin
                            ctl.clr_idx = 1'b1;
                            state_next  = ST_CANCEL;
                        end
                        asq_pkg::CMD_SIGNAL: state_next = ST_SIGNAL;
                        default:             state_next = ST_STATUS;
                    endcase
                end
                else if (sts.expired)
                begin
                    // removal keeps the index so the shifted-in entry is checked
                    if (sts.out_free)
                    begin
                        ctl.drop = 1'b1;
                    end
                end
                else
                begin
                    ctl.inc_idx = 1'b1;
                end
            end
            ST_CANCEL:
            begin
                if (!sts.queue_nz)
                begin
                    state_next = ST_STATUS;
                end
                else if (sts.out_free)
                begin
                    ctl.drop     = 1'b1;
                    ctl.drop_ack = 1'b1;
                    state_next   = ST_STATUS;
                end
            end
            ST_SIGNAL:
            begin
                ctl.do_signal = 1'b1;
                state_next    = ST_STATUS;
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    ctl.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/asq_dp.sv =====
`timescale 1ns / 1ps

module asq_dp
#(
    parameter int SOURCES = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [asq_pkg::CFG_WIDTH-1:0]  cfg_data,
    input  asq_pkg::in_item_t              in_payload,
    input  asq_pkg::ctl_t                  ctl,
    output asq_pkg::sts_t                  sts,
    output logic                           out_valid,
    input  logic                           out_ready,
    output asq_pkg::out_item_t             out_payload
);

    localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int CW = $clog2(SOURCES + 1);

    logic [31:0] timeout_reg;
    logic [14:0] mode_reg;
    logic [19:0] melody_tab_reg;
    logic [39:0] volume_tab_reg;

    logic [IW-1:0] queue_order_reg [SOURCES];
    logic [31:0]   receive_time_reg [SOURCES];
    logic [31:0]   last_sig_reg [SOURCES];
    logic [CW-1:0] size_reg;
    logic [CW-1:0] idx_reg;

    asq_pkg::in_item_t item_reg;
    logic              snd_reg;
    logic              vib_reg;
    logic              led_reg;
    logic [3:0]        melody_reg;
    logic [7:0]        volume_reg;

    logic               out_valid_reg;
    asq_pkg::out_item_t out_reg;
    asq_pkg::out_item_t out_next;
    logic               out_load;

    logic [IW-1:0] q_at;
    logic [31:0]   rt_at;
    logic          expired;

    logic [IW-1:0] si;
    logic          src_ok;
    logic [31:0]   prev;
    logic [31:0]   hold;
    logic          pass;
    logic          found;
    logic [2:0]    mode_bits;

    assign q_at    = queue_order_reg[idx_reg[IW-1:0]];
    assign rt_at   = receive_time_reg[q_at];
    assign expired = {1'b0, item_reg.now_ms} > ({1'b0, rt_at} + {1'b0, timeout_reg});

    assign si     = item_reg.source[IW-1:0];
    assign src_ok = 4'(item_reg.source) < 4'(SOURCES);
    assign prev   = last_sig_reg[si];

    always_comb
    begin
        if (item_reg.source == asq_pkg::SRC_FIRST)
        begin
            hold = asq_pkg::HOLD_FIRST;
        end
        else if (item_reg.source == asq_pkg::SRC_LAST)
        begin
            hold = asq_pkg::HOLD_LAST;
        end
        else
        begin
            hold = asq_pkg::HOLD_OTHER;
        end
    end

    assign pass = src_ok &&
                  ((prev == 32'd0) ||
                   ({1'b0, item_reg.now_ms} > ({1'b0, prev} + {1'b0, hold})));

    always_comb
    begin
        found = 1'b0;
        for (int k = 0; k < SOURCES; k++)
        begin
            if ((CW'(k) < size_reg) && (queue_order_reg[k] == si))
            begin
                found = 1'b1;
            end
        end
    end

    assign mode_bits = 3'(mode_reg >> (5'(item_reg.source) * 5'd3));

    assign out_load = ctl.drop || ctl.emit_status;

    always_comb
    begin
        out_next = '0;
        if (ctl.drop)
        begin
            out_next.src_index     = 3'(q_at);
            out_next.acknowledged  = ctl.drop_ack;
            out_next.alert_time_ms = rt_at;
        end
        else
        begin
            out_next.kind             = 1'b1;
            out_next.src_index        = (size_reg != '0) ? 3'(queue_order_reg[0]) : 3'd0;
            out_next.sound_start      = snd_reg;
            out_next.melody           = melody_reg;
            out_next.volume           = volume_reg;
            out_next.vibro_enable     = vib_reg;
            out_next.led_enable       = led_reg;
            out_next.indications_stop = (size_reg == '0);
            out_next.queue_count      = 3'(size_reg);
            out_next.last             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= asq_pkg::TIMEOUT_RESET;
            mode_reg       <= asq_pkg::MODE_RESET;
            melody_tab_reg <= '0;
            volume_tab_reg <= '0;
            size_reg       <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < SOURCES; k++)
            begin
                last_sig_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    asq_pkg::REG_TIMEOUT: timeout_reg    <= cfg_data[31:0];
                    asq_pkg::REG_MODE:    mode_reg       <= cfg_data[14:0];
                    asq_pkg::REG_MELODY:  melody_tab_reg <= cfg_data[19:0];
                    asq_pkg::REG_VOLUME:  volume_tab_reg <= cfg_data[39:0];
                    default:              timeout_reg    <= timeout_reg;
                endcase
            end

            if (ctl.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (ctl.inc_idx)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            if (ctl.drop)
            begin
                size_reg <= size_reg - CW'(1);
            end
            else if (ctl.do_signal && pass && !found && (size_reg < CW'(SOURCES)))
            begin
                size_reg <= size_reg + CW'(1);
            end

            if (ctl.do_signal && pass)
            begin
                last_sig_reg[si] <= item_reg.now_ms;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg   <= in_payload;
            snd_reg    <= 1'b0;
            vib_reg    <= 1'b0;
            led_reg    <= 1'b0;
            melody_reg <= '0;
            volume_reg <= '0;
        end

        if (ctl.drop)
        begin
            for (int k = 0; k < SOURCES - 1; k++)
            begin
                if (CW'(k) >= idx_reg)
                begin
                    queue_order_reg[k] <= queue_order_reg[k + 1];
                end
            end
        end

        if (ctl.do_signal && pass)
        begin
            receive_time_reg[si] <= item_reg.now_ms;
            if (!found && (size_reg < CW'(SOURCES)))
            begin
                queue_order_reg[size_reg[IW-1:0]] <= si;
            end
            snd_reg <= mode_bits[0];
            vib_reg <= mode_bits[1];
            led_reg <= mode_bits[2];
            if (mode_bits[0])
            begin
                melody_reg <= 4'(melody_tab_reg >> (5'(item_reg.source) * 5'd4));
                volume_reg <= 8'(volume_tab_reg >> (6'(item_reg.source) * 6'd8));
            end
        end

        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.scan_more = idx_reg < size_reg;
    assign sts.expired   = expired;
    assign sts.queue_nz  = size_reg != '0;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.cmd       = item_reg.cmd;

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

endmodule
